// ===== src/bbe_pkg.sv =====
// Package: constants, types and weight tables for the bilateral blur energy unit.
package bbe_pkg;

	localparam int COORD_W     = 8;
	localparam int DIM_W       = 9;
	localparam int ENERGY_W    = 16;
	localparam int WGT_W       = 16;
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int RADIUS      = 2;
	localparam int SPAN        = 2 * RADIUS + 1;
	localparam int TAP_W       = $clog2(SPAN);
	localparam int RANGE_N     = 64;
	localparam int RANGE_SHIFT = 8;
	localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int WSUM_W      = 21;
	localparam int ACC_W       = WSUM_W + ENERGY_W;
	localparam int DIV_STEPS   = ENERGY_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W   = 1;

	localparam logic [31:0] SPATIAL_BASE = 32'd3035031097;
	localparam logic [31:0] RANGE_BASE   = 32'd4271728703;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ACT_STORE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_FIRST,
		ST_W1,
		ST_W2,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef logic [SPAN-1:0][SPAN-1:0][WGT_W-1:0] spatial_tab_t;
	typedef logic [RANGE_N-1:0][WGT_W-1:0]         range_tab_t;

	// base^n in Q0.32 with rounding at each step, then rounded to Q0.16
	function automatic logic [WGT_W-1:0] weight_pow(logic [31:0] base, int unsigned n);
		logic [95:0] acc;
		int unsigned i;
		acc = 96'd1 << 32;
		for (i = 0; i < n; i++) begin
			acc = (acc * {64'd0, base} + (96'd1 << 31)) >> 32;
		end
		acc = (acc + 96'd32768) >> 16;
		return (acc > 96'd65535) ? 16'hFFFF : acc[WGT_W-1:0];
	endfunction

	function automatic spatial_tab_t build_spatial();
		spatial_tab_t t;
		int unsigned ay;
		int unsigned ax;
		for (int y = 0; y < SPAN; y++) begin
			for (int x = 0; x < SPAN; x++) begin
				ay = (y > RADIUS) ? (y - RADIUS) : (RADIUS - y);
				ax = (x > RADIUS) ? (x - RADIUS) : (RADIUS - x);
				t[y][x] = weight_pow(SPATIAL_BASE, ay * ay + ax * ax);
			end
		end
		return t;
	endfunction

	function automatic range_tab_t build_range();
		range_tab_t t;
		for (int k = 0; k < RANGE_N; k++) begin
			t[k] = weight_pow(RANGE_BASE, k * k);
		end
		return t;
	endfunction

	localparam spatial_tab_t SPATIAL_W = build_spatial();
	localparam range_tab_t   RANGE_W   = build_range();

endpackage

// ===== src/bbe_if.sv =====
// Interfaces: input item channel and result channel.
interface bbe_in_if;
	import bbe_pkg::*;
	logic                valid;
	logic                ready;
	logic                action;
	logic [COORD_W-1:0]  pixel_x;
	logic [COORD_W-1:0]  pixel_y;
	logic [ENERGY_W-1:0] energy;

	modport source(output valid, output action, output pixel_x, output pixel_y,
		output energy, input ready);
	modport sink(input valid, input action, input pixel_x, input pixel_y,
		input energy, output ready);
endinterface

interface bbe_out_if;
	import bbe_pkg::*;
	logic                valid;
	logic                ready;
	logic [ENERGY_W-1:0] filtered_energy;
	logic [COORD_W-1:0]  out_x;
	logic [COORD_W-1:0]  out_y;

	modport source(output valid, output filtered_energy, output out_x, output out_y,
		input ready);
	modport sink(input valid, input filtered_energy, input out_x, input out_y,
		output ready);
endinterface

// ===== src/bilateral_blur_energy_unit.sv =====
// Top level: frame store with an iterative 5x5 bilateral filter and serial divider.
//
//  channel   | dir | transfer carries
//  ----------+-----+------------------------------------------------
//  in_ch     | in  | action, pixel_x, pixel_y, energy
//  out_ch    | out | filtered_energy, out_x, out_y (one per in-range query)
//  cfg_*     | in  | register index and data, written when cfg_we
//
// A store is written in the cycle it is accepted. A query reads the centre sample, then
// the single memory port and shared 16x16 multiplier serve the 25 taps in W1 and W2,
// then a restoring divider yields one quotient bit a cycle. in_ch is ready only in idle.
// The result register holds a finished result while out_ch stalls; a new item can be
// taken meanwhile. Reset sets control and dimensions, not datapath or frame store.
module bilateral_blur_energy_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	bbe_in_if.sink                        in_ch,
	bbe_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbe_pkg::DIM_W-1:0]     cfg_data
);
	import bbe_pkg::*;

	state_t state_q, state_nx;

	logic [DIM_W-1:0]    width_q, height_q;
	logic [DIM_W-1:0]    eff_w, eff_h;
	logic [COORD_W-1:0]  px_q, py_q;
	logic [TAP_W-1:0]    kx_q, ky_q;
	logic [TAP_W-1:0]    kx_nx, ky_nx;
	logic                last_tap;
	logic [ENERGY_W-1:0] centre_q, nb_q, rdata_q;
	logic [31:0]         prod_q;
	logic [ACC_W-1:0]    acc_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [WSUM_W-1:0]   rem_q;
	logic [ENERGY_W-1:0] nq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                ovalid_q;
	logic [ENERGY_W-1:0] ores_q;
	logic [COORD_W-1:0]  ox_q, oy_q;

	logic [ENERGY_W-1:0] mem [MEM_DEPTH];
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [WGT_W-1:0]    mul_a, mul_b;
	logic [31:0]         prod;
	logic                in_fire, in_range, out_free;
	logic [ENERGY_W-1:0] diff;
	logic [ENERGY_W:0]   diff_rnd;
	logic [ENERGY_W-RANGE_SHIFT:0] kk;
	logic [WGT_W-1:0]    rw, sw;
	logic [32:0]         wgt_rnd;
	logic [WGT_W-1:0]    wgt;
	logic [ACC_W-1:0]    num;
	logic [WSUM_W:0]     trial;
	logic [WSUM_W:0]     trial_sub;
	logic [TAP_W-1:0]    ax_rd, ay_rd;

	// clamp a window coordinate to the image
	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] p,
		logic [TAP_W-1:0] k, logic [DIM_W-1:0] lim);
		logic signed [COORD_W+2:0] s;
		s = $signed({3'b000, p}) + $signed({{(COORD_W+3-TAP_W){1'b0}}, k})
			- (COORD_W+3)'(RADIUS);
		if (s < 0) begin
			return '0;
		end else if (s >= $signed({2'b00, lim})) begin
			return COORD_W'(lim - DIM_W'(1));
		end
		return s[COORD_W-1:0];
	endfunction

	// effective dimensions: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		eff_w = (width_q == '0) ? DIM_W'(1)
			: ((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
		eff_h = (height_q == '0) ? DIM_W'(1)
			: ((height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q);
	end

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign in_range = ({1'b0, in_ch.pixel_x} < eff_w) && ({1'b0, in_ch.pixel_y} < eff_h);
	assign out_free = !ovalid_q || out_ch.ready;

	// next tap in row-major order
	always_comb begin
		last_tap = (kx_q == TAP_W'(SPAN - 1)) && (ky_q == TAP_W'(SPAN - 1));
		if (kx_q == TAP_W'(SPAN - 1)) begin
			kx_nx = '0;
			ky_nx = ky_q + TAP_W'(1);
		end else begin
			kx_nx = kx_q + TAP_W'(1);
			ky_nx = ky_q;
		end
	end

	// per-tap weight terms from the sample read last cycle, and the divider's trial step
	always_comb begin
		diff     = (rdata_q > centre_q) ? (rdata_q - centre_q) : (centre_q - rdata_q);
		diff_rnd = {1'b0, diff} + (ENERGY_W+1)'(1 << (RANGE_SHIFT - 1));
		kk       = diff_rnd[ENERGY_W:RANGE_SHIFT];
		rw       = (kk < (ENERGY_W-RANGE_SHIFT+1)'(RANGE_N))
			? RANGE_W[kk[$clog2(RANGE_N)-1:0]] : '0;
		sw       = SPATIAL_W[ky_q][kx_q];
		wgt_rnd  = {1'b0, prod_q} + 33'd32768;
		wgt      = wgt_rnd[31:16];
		num      = acc_q + ACC_W'(wsum_q >> 1);
		trial    = {rem_q, nq_q[ENERGY_W-1]};
		trial_sub = trial - {1'b0, wsum_q};
	end

	assign prod = {16'd0, mul_a} * {16'd0, mul_b};

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_range && (in_ch.action == ACT_QUERY)) begin
					state_nx = ST_CENTRE;
				end
			end
			ST_CENTRE: state_nx = ST_FIRST;
			ST_FIRST:  state_nx = ST_W1;
			ST_W1:     state_nx = ST_W2;
			ST_W2:     state_nx = last_tap ? ST_PREP : ST_W1;
			ST_PREP:   state_nx = ST_DIV;
			ST_DIV:    state_nx = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) ? ST_DONE : ST_DIV;
			ST_DONE:   state_nx = out_free ? ST_IDLE : ST_DONE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// memory address, multiplier operands and ready
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = {in_ch.pixel_y, in_ch.pixel_x};
		mul_a    = sw;
		mul_b    = rw;
		ay_rd    = ky_nx;
		ax_rd    = kx_nx;
		case (state_q)
			ST_IDLE: begin
				mem_we = in_fire && in_range && (in_ch.action == ACT_STORE);
			end
			ST_CENTRE: mem_addr = {py_q, px_q};
			ST_FIRST: begin
				ay_rd    = '0;
				ax_rd    = '0;
				mem_addr = {clamp_coord(py_q, ay_rd, eff_h), clamp_coord(px_q, ax_rd, eff_w)};
			end
			ST_W1: begin
				mem_addr = {clamp_coord(py_q, ay_rd, eff_h), clamp_coord(px_q, ax_rd, eff_w)};
			end
			ST_W2: begin
				mul_a = nb_q;
				mul_b = wgt;
				// hold the next tap's sample on the read port
				mem_addr = {clamp_coord(py_q, ay_rd, eff_h), clamp_coord(px_q, ax_rd, eff_w)};
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	// frame store: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= in_ch.energy;
		end
		rdata_q <= mem[mem_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
			kx_q     <= '0;
			ky_q     <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE) begin
				kx_q <= '0;
				ky_q <= '0;
			end else if (state_q == ST_W2) begin
				kx_q <= kx_nx;
				ky_q <= ky_nx;
			end
			if (state_q == ST_PREP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			// load a finished result, else drop a delivered one
			if (state_q == ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= in_ch.pixel_x;
				py_q   <= in_ch.pixel_y;
				acc_q  <= '0;
				wsum_q <= '0;
			end
			ST_FIRST: centre_q <= rdata_q;
			ST_W1: begin
				nb_q   <= rdata_q;
				prod_q <= prod;
			end
			ST_W2: begin
				acc_q  <= acc_q + ACC_W'(prod);
				wsum_q <= wsum_q + WSUM_W'(wgt);
			end
			ST_PREP: begin
				rem_q <= num[ACC_W-1:ENERGY_W];
				nq_q  <= num[ENERGY_W-1:0];
			end
			ST_DIV: begin
				// one restoring step: shift in a numerator bit, subtract if it fits
				if (!trial_sub[WSUM_W]) begin
					rem_q <= trial_sub[WSUM_W-1:0];
					nq_q  <= {nq_q[ENERGY_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[WSUM_W-1:0];
					nq_q  <= {nq_q[ENERGY_W-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ores_q <= (wsum_q == '0) ? '0 : nq_q;
					ox_q   <= px_q;
					oy_q   <= py_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid           = ovalid_q;
	assign out_ch.filtered_energy = ores_q;
	assign out_ch.out_x           = ox_q;
	assign out_ch.out_y           = oy_q;

endmodule

// ===== dv/tb_bilateral_blur_energy_unit.sv =====
// Testbench for the bilateral blur energy unit: directed and random store/query traffic.
module tb_bilateral_blur_energy_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import bbe_pkg::*;

	typedef struct {
		logic [ENERGY_W-1:0] energy;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
	} blur_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;

	bbe_in_if  in_ch();
	bbe_out_if out_ch();

	bilateral_blur_energy_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the block: frame, dimension registers and weight tables
	logic [ENERGY_W-1:0] frame_shadow [MEM_DEPTH];
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [WGT_W-1:0] gauss_tab [SPAN][SPAN];
	logic [WGT_W-1:0] range_tab [RANGE_N];

	blur_result_t blur_expected [$];
	int errors;
	bit idle_on;
	bit stall_on;
	int long_hold;
	int stall_left;

	function automatic logic [WGT_W-1:0] decay_weight(logic [31:0] base, int unsigned steps);
		logic [95:0] w;
		w = 96'd1 << 32;
		repeat (steps) w = (w * base + (96'd1 << 31)) >> 32;
		w = (w + 96'd32768) >> 16;
		return (w > 96'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic int dim_in_use(logic [DIM_W-1:0] r, int maxv);
		if (r == 0) return 1;
		return (r > maxv) ? maxv : int'(r);
	endfunction

	function automatic int clip_coord(int v, int lim);
		if (v < 0) return 0;
		if (v >= lim) return lim - 1;
		return v;
	endfunction

	// weighted mean of the clamped 5x5 window around (px, py)
	function automatic logic [ENERGY_W-1:0] blur_at(int px, int py, int w, int h);
		logic [63:0] acc;
		logic [63:0] wsum;
		logic [63:0] q;
		logic [31:0] centre;
		logic [31:0] nb;
		logic [31:0] diff;
		logic [31:0] k;
		logic [31:0] rw;
		logic [63:0] wgt;
		int sx;
		int sy;
		acc = 0;
		wsum = 0;
		q = 0;
		centre = 32'(frame_shadow[py * MAX_WIDTH + px]);
		for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
			sy = clip_coord(py + dy, h);
			for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
				sx = clip_coord(px + dx, w);
				nb = 32'(frame_shadow[sy * MAX_WIDTH + sx]);
				diff = (nb > centre) ? nb - centre : centre - nb;
				k = (diff + 128) >> RANGE_SHIFT;
				rw = (k < RANGE_N) ? 32'(range_tab[k]) : 32'd0;
				wgt = (64'(gauss_tab[dy < 0 ? -dy : dy][dx < 0 ? -dx : dx]) * rw + 32768) >> 16;
				acc += nb * wgt;
				wsum += wgt;
			end
		end
		if (wsum != 0) q = (acc + wsum / 2) / wsum;
		if (q > 65535) q = 65535;
		return q[15:0];
	endfunction

	// update the shadow for one accepted item and queue the result it causes
	task automatic apply_item(action_t act, int px, int py, logic [ENERGY_W-1:0] e);
		int w;
		int h;
		blur_result_t r;
		w = dim_in_use(width_reg, MAX_WIDTH);
		h = dim_in_use(height_reg, MAX_HEIGHT);
		if (px >= w || py >= h) return;
		if (act == ACT_STORE) begin
			frame_shadow[py * MAX_WIDTH + px] = e;
		end else begin
			r.energy = blur_at(px, py, w, h);
			r.x = COORD_W'(px);
			r.y = COORD_W'(py);
			blur_expected.push_back(r);
		end
	endtask

	// offer one item, with an optional idle burst first, and wait for the transfer
	task automatic send_item(action_t act, int px, int py, logic [ENERGY_W-1:0] e);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.action  <= act;
		in_ch.pixel_x <= COORD_W'(px);
		in_ch.pixel_y <= COORD_W'(py);
		in_ch.energy  <= e;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		apply_item(act, px, py, e);
	endtask

	// drop valid, wait for every result, then let a store in flight settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (blur_expected.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_dims(int w, int h);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= DIM_W'(w);
		@(posedge clk);
		width_reg = DIM_W'(w);
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= DIM_W'(h);
		@(posedge clk);
		height_reg = DIM_W'(h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [ENERGY_W-1:0] near_energy(int base);
		int v;
		if ($urandom_range(0, 9) == 0) return ENERGY_W'($urandom_range(0, 65535));
		v = base + $urandom_range(0, 3071);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// frame corners at full size, extreme samples
	task automatic test_corners();
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++)
				send_item(ACT_STORE, x, y, ((x + y) % 2) ? 16'hFFFF : 16'h0000);
		send_item(ACT_QUERY, 0, 0, 16'hFFFF);
		send_item(ACT_QUERY, 1, 1, 16'h0000);
		for (int y = 252; y < 256; y++)
			for (int x = 252; x < 256; x++)
				send_item(ACT_STORE, x, y, 16'h8000 + 16'((x - 253) * 40 + (y - 253) * 9));
		send_item(ACT_QUERY, 255, 255, 16'h0);
		send_item(ACT_QUERY, 254, 254, 16'h0);
	endtask

	// zero dimensions act as one, oversize as the maximum; out-of-image items
	task automatic test_dim_limits();
		set_dims(0, 0);
		send_item(ACT_STORE, 0, 0, 16'h1234);
		send_item(ACT_STORE, 1, 0, 16'hFFFF);
		send_item(ACT_QUERY, 0, 0, 16'h0);
		send_item(ACT_QUERY, 0, 1, 16'h0);
		send_item(ACT_QUERY, 255, 255, 16'h0);
		set_dims(511, 300);
		send_item(ACT_QUERY, 255, 255, 16'h0);
		send_item(ACT_QUERY, 254, 254, 16'h0);
	endtask

	// fill the whole image, then mix queries, stores and out-of-image items
	task automatic test_random_mix(int w, int h, int n, bit hold);
		int base;
		int r;
		set_dims(w, h);
		base = $urandom_range(0, 62000);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				send_item(ACT_STORE, x, y, near_energy(base));
		if (hold) long_hold = 400;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				send_item(ACT_QUERY, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
					ENERGY_W'($urandom_range(0, 65535)));
			else if (r < 8)
				send_item(ACT_STORE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
					near_energy(base));
			else
				send_item(action_t'($urandom_range(0, 1)), $urandom_range(0, 255),
					$urandom_range(0, 255), ENERGY_W'($urandom_range(0, 65535)));
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check each transfer, then pick next ready
	initial begin
		out_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (blur_expected.size() == 0) begin
					$display("%0t: unexpected result energy=%h x=%0d y=%0d", $time,
						out_ch.filtered_energy, out_ch.out_x, out_ch.out_y);
					errors++;
				end else begin
					automatic blur_result_t e = blur_expected.pop_front();
					if (out_ch.filtered_energy !== e.energy) begin
						$display("%0t: filtered_energy expected %h actual %h", $time,
							e.energy, out_ch.filtered_energy);
						errors++;
					end
					if (out_ch.out_x !== e.x) begin
						$display("%0t: out_x expected %0d actual %0d", $time, e.x, out_ch.out_x);
						errors++;
					end
					if (out_ch.out_y !== e.y) begin
						$display("%0t: out_y expected %0d actual %0d", $time, e.y, out_ch.out_y);
						errors++;
					end
				end
			end
			if (long_hold > 0) begin
				long_hold--;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	// sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_STORE;
		in_ch.pixel_x = '0;
		in_ch.pixel_y = '0;
		in_ch.energy = '0;
		errors = 0;
		long_hold = 0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		width_reg = DIM_W'(256);
		height_reg = DIM_W'(256);
		for (int i = 0; i < MEM_DEPTH; i++) frame_shadow[i] = '0;
		for (int a = 0; a < SPAN; a++)
			for (int b = 0; b < SPAN; b++)
				gauss_tab[a][b] = decay_weight(SPATIAL_BASE, a * a + b * b);
		for (int k = 0; k < RANGE_N; k++) range_tab[k] = decay_weight(RANGE_BASE, k * k);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_dim_limits();
		test_random_mix(8, 8, 150, 1'b1);
		test_random_mix(1, 7, 100, 1'b0);
		test_random_mix(16, 9, 150, 1'b0);
		test_random_mix(256, 1, 150, 1'b0);
		test_random_mix(2, 40, 120, 1'b0);
		idle_on = 1'b0;
		stall_on = 1'b0;
		test_random_mix(13, 13, 150, 1'b0);

		drain();
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
